// ===== sv/ump_pkg.sv =====
package ump_pkg;

   // measurement setup
   localparam int SHOTS      = 5;
   localparam int SHOT_W     = (SHOTS > 1) ? $clog2(SHOTS) : 1;
   localparam int MEDIAN_IDX = SHOTS / 2;

   // field widths
   localparam int TICK_W = 16;
   localparam int TRIG_W = 8;
   localparam int CM_W   = 11;
   localparam int REM_W  = 10;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   // register reset values
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RESET = 16'd18000;
   localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RESET = 8'd10;
   // distance of the default timeout reading of 17647 ticks
   localparam logic [CM_W-1:0]   TIMEOUT_CM_RESET    = 11'd299;

   // ticks to cm: 17 cm per 1000 ticks
   localparam logic [REM_W-1:0] CM_STEP    = 10'd17;
   localparam logic [REM_W-1:0] CM_DIVISOR = 10'd1000;
   localparam logic [CM_W-1:0]  CM_MAX     = 11'd1114;

   // reciprocal of 1000 scaled by 2^30, exact for 21-bit numerators
   localparam int RECIP_SHIFT = 30;
   localparam logic [20:0] RECIP_1000 = 21'd1073742;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TIMEOUT_TICKS   = 2'd0,
      CSR_TIMEOUT_READING = 2'd1,
      CSR_TRIGGER_TICKS   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_WAIT,
      PH_HIGH
   } phase_type;

   typedef struct packed {
      logic start_req;
      logic echo_level;
   } req_type;

   typedef struct packed {
      logic            trigger_level;
      logic            busy_res;
      logic            distance_valid;
      logic [CM_W-1:0] range_cm;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0] timeout_ticks;
      logic [TRIG_W-1:0] trigger_ticks;
      logic [CM_W-1:0]   timeout_cm;
   } cfg_type;

   // per-tick control result from the sequencer
   typedef struct packed {
      logic              trigger_level;
      logic              busy_res;
      logic              finish;
      logic              done;
      logic [SHOT_W-1:0] index;
      logic [CM_W-1:0]   reading_cm;
   } shot_type;

   // floor(pulse * 17 / 1000) by shift-add and one reciprocal multiply
   function automatic logic [CM_W-1:0] pulse_to_cm(input logic [TICK_W-1:0] pulse);
      logic [20:0] scaled;
      logic [41:0] prod;
      scaled = {1'b0, pulse, 4'b0000} + {5'b00000, pulse};
      prod   = {21'd0, scaled} * {21'd0, RECIP_1000};
      return prod[RECIP_SHIFT+CM_W-1:RECIP_SHIFT];
   endfunction

endpackage

// ===== sv/ump_ctrl.sv =====
module ump_ctrl
   import ump_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  req_type  req,
   input  cfg_type  cfg,
   output shot_type ev
);

   phase_type         phase_ff, phase_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [SHOT_W-1:0] shot_ff, shot_in;
   logic [CM_W-1:0]   cm_ff, cm_in;
   logic [REM_W-1:0]  rem_ff, rem_in;

   logic [TICK_W-1:0] tick_plus;
   logic [REM_W-1:0]  rem_sum;
   phase_type         ph;

   // state registers, advanced once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         shot_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         shot_ff  <= shot_in;
      end
   end

   // running distance of the high echo, payload only
   always_ff @(posedge clock) begin
      if (step) begin
         cm_ff  <= cm_in;
         rem_ff <= rem_in;
      end
   end

   // next state and per-tick outputs
   always_comb begin
      ph        = phase_ff;
      tick_in   = tick_ff;
      shot_in   = shot_ff;
      cm_in     = cm_ff;
      rem_in    = rem_ff;
      tick_plus = tick_ff + 16'd1;
      rem_sum   = rem_ff + CM_STEP;
      ev        = '0;

      // start only from idle
      if (phase_ff == PH_IDLE && req.start_req) begin
         ph      = PH_TRIG;
         tick_in = '0;
         shot_in = '0;
      end
      phase_in = ph;

      unique case (ph)
         PH_IDLE: begin
         end
         PH_TRIG: begin
            ev.trigger_level = 1'b1;
            if (tick_plus >= {{(TICK_W-TRIG_W){1'b0}}, cfg.trigger_ticks}) begin
               phase_in = PH_WAIT;
               tick_in  = '0;
            end else begin
               tick_in = tick_plus;
            end
         end
         PH_WAIT: begin
            if (req.echo_level) begin
               phase_in = PH_HIGH;
               tick_in  = '0;
               cm_in    = '0;
               rem_in   = '0;
            end else if (tick_ff >= cfg.timeout_ticks) begin
               ev.finish     = 1'b1;
               ev.reading_cm = cfg.timeout_cm;
            end else begin
               tick_in = tick_plus;
            end
         end
         PH_HIGH: begin
            if (!req.echo_level) begin
               ev.finish     = 1'b1;
               ev.reading_cm = cm_ff;
            end else if (tick_ff >= cfg.timeout_ticks) begin
               ev.finish     = 1'b1;
               ev.reading_cm = cfg.timeout_cm;
            end else begin
               tick_in = tick_plus;
               // 17 cm per 1000 ticks, carried as quotient and remainder
               if (rem_sum >= CM_DIVISOR) begin
                  rem_in = rem_sum - CM_DIVISOR;
                  cm_in  = cm_ff + 11'd1;
               end else begin
                  rem_in = rem_sum;
               end
            end
         end
      endcase

      // end of a shot: next trigger or the median
      ev.index = shot_ff;
      if (ev.finish) begin
         tick_in = '0;
         if (shot_ff == SHOT_W'(SHOTS - 1)) begin
            ev.done  = 1'b1;
            phase_in = PH_IDLE;
            shot_in  = '0;
         end else begin
            phase_in = PH_TRIG;
            shot_in  = shot_ff + SHOT_W'(1);
         end
      end

      ev.busy_res = (phase_in != PH_IDLE);
   end

endmodule

// ===== sv/ump_sort.sv =====
module ump_sort
   import ump_pkg::*;
(
   input  logic            clock,
   input  logic            step,
   input  shot_type        ev,
   output logic [CM_W-1:0] median
);

   logic [CM_W-1:0] sorted_ff [SHOTS];
   logic [CM_W-1:0] sorted_in [SHOTS];
   logic [SHOTS-1:0] le;

   // insertion into the ascending list of this measurement's shots
   always_comb begin
      for (int i = 0; i < SHOTS; i++) begin
         le[i] = (SHOT_W'(i) < ev.index) && (sorted_ff[i] <= ev.reading_cm);
      end
      for (int i = 0; i < SHOTS; i++) begin
         if (le[i]) begin
            sorted_in[i] = sorted_ff[i];
         end else if (i == 0) begin
            sorted_in[i] = ev.reading_cm;
         end else if (le[i-1]) begin
            sorted_in[i] = ev.reading_cm;
         end else begin
            sorted_in[i] = sorted_ff[i-1];
         end
      end
      median = sorted_in[MEDIAN_IDX];
   end

   // list storage
   always_ff @(posedge clock) begin
      if (step && ev.finish) begin
         for (int i = 0; i < SHOTS; i++) begin
            sorted_ff[i] <= sorted_in[i];
         end
      end
   end

endmodule

// ===== sv/ultrasonic_median_ranger.sv =====
// channel   direction  handshake             payload
// req       in         req_valid/req_ready   req_data  (start_req, echo_level)
// rsp       out        rsp_valid/rsp_ready   rsp_data  (trigger, busy, valid, cm)
// csr       in         csr_valid/csr_ready   csr_index, csr_wdata
//
// one request, one tick, per cycle while the response register is empty or
// draining; each request gives one response, registered, in the next cycle
// the median of five comes from a sorted list kept by insertion per shot
// reset: synchronous, no clearing pass; csr_ready is always high
// a stalled response holds req_ready low only while rsp_ready is low
module ultrasonic_median_ranger
   import ump_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TICK_W-1:0] timeout_ticks_ff;
   logic [TRIG_W-1:0] trigger_ticks_ff;
   logic [CM_W-1:0]   timeout_cm_ff;
   cfg_type           cfg;

   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              step;
   shot_type          ev;
   logic [CM_W-1:0]   median;

   assign csr_ready = 1'b1;

   // configuration registers; the timeout reading is kept as its distance
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= TIMEOUT_TICKS_RESET;
         trigger_ticks_ff <= TRIGGER_TICKS_RESET;
         timeout_cm_ff    <= TIMEOUT_CM_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT_TICKS:   timeout_ticks_ff <= csr_wdata;
            CSR_TIMEOUT_READING: timeout_cm_ff    <= pulse_to_cm(csr_wdata);
            CSR_TRIGGER_TICKS:   trigger_ticks_ff <= csr_wdata[TRIG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg.timeout_ticks = timeout_ticks_ff;
   assign cfg.trigger_ticks = trigger_ticks_ff;
   assign cfg.timeout_cm    = timeout_cm_ff;

   // accept while the response register is empty or draining
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   ump_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .req   (req_data),
      .cfg   (cfg),
      .ev    (ev)
   );

   ump_sort u_sort (
      .clock  (clock),
      .step   (step),
      .ev     (ev),
      .median (median)
   );

   // response assembly
   always_comb begin
      rsp_data_in.trigger_level  = ev.trigger_level;
      rsp_data_in.busy_res       = ev.busy_res;
      rsp_data_in.distance_valid = ev.done;
      rsp_data_in.range_cm       = ev.done ? median : '0;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/ump_checker.sv =====
module ump_checker
   import ump_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // nothing left in the response register after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // the median tick ends the measurement
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.distance_valid |-> !rsp_data.busy_res)
      else $error("median delivered while still busy");

   // distance only with its flag, and within range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.distance_valid || rsp_data.range_cm == '0)
                    && rsp_data.range_cm <= CM_MAX)
      else $error("distance field out of place");

   // trigger is only driven during a measurement
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.trigger_level |-> rsp_data.busy_res)
      else $error("trigger while idle");

endmodule

bind ultrasonic_median_ranger ump_checker u_ump_checker (.*);
